// ===== sv/srpg_pkg.sv =====
`default_nettype none

package srpg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int THRESH_W    = 32;
    localparam int STEP_W      = 16;
    localparam int WIDE_W      = 33;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_START_PERIOD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_DECREMENT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_INCREMENT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_ENABLE     = 3'd6;

    localparam logic [STEP_W-1:0]   RST_START_PERIOD    = 16'd300;
    localparam logic [STEP_W-1:0]   RST_MIN_PERIOD      = 16'd50;
    localparam logic [STEP_W-1:0]   RST_MAX_PERIOD      = 16'd400;
    localparam logic [THRESH_W-1:0] RST_DECEL_THRESHOLD = 32'd50;
    localparam logic [STEP_W-1:0]   RST_ACCEL_DECREMENT = 16'd1;
    localparam logic [STEP_W-1:0]   RST_DECEL_INCREMENT = 16'd1;

    typedef struct packed {
        logic step_pin;
        logic dir_pin;
        logic enable_n;
        logic busy;
        logic done;
        logic rejected;
    } res_flags_t;

endpackage

`default_nettype wire

// ===== sv/stepper_ramp_pulse_generator.sv =====
// An accepted input beat waits in the input register; its result goes to the m_ side
// through the result register. Throughput: one beat per cycle while m_ready allows it;
// the state updates once per beat. The input register and the result register let a
// new beat enter while a result waits. Reset (aresetn low, synchronous): registers
// return to their defaults, move idle, step and direction state low, driver disabled.
`default_nettype none

module stepper_ramp_pulse_generator import srpg_pkg::*; #(
    parameter int COUNT_WIDTH  = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_opcode,
    input  wire logic                    s_direction,
    input  wire logic [COUNT_WIDTH-1:0]  s_step_count,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_step_pin,
    output logic                         m_dir_pin,
    output logic                         m_enable_n,
    output logic                         m_busy_res,
    output logic                         m_move_done,
    output logic                         m_start_rejected,
    output logic      [PERIOD_WIDTH-1:0] m_current_period,
    output logic      [COUNT_WIDTH-1:0]  m_steps_left
);

    logic                    in_valid_reg;
    logic                    opcode_reg, direction_reg;
    logic [COUNT_WIDTH-1:0]  step_count_reg;
    logic                    out_valid_reg;
    res_flags_t              flags_reg, flags;
    logic [PERIOD_WIDTH-1:0] period_reg, period;
    logic [COUNT_WIDTH-1:0]  steps_reg, steps;
    logic                    advance, fire, take;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            opcode_reg     <= s_opcode;
            direction_reg  <= s_direction;
            step_count_reg <= s_step_count;
        end
        if (fire) begin
            flags_reg  <= flags;
            period_reg <= period;
            steps_reg  <= steps;
        end
    end

    srpg_engine #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fire          (fire),
        .opcode        (opcode_reg),
        .direction     (direction_reg),
        .step_count    (step_count_reg),
        .flags         (flags),
        .period_out    (period),
        .remaining_out (steps)
    );

    assign m_valid          = out_valid_reg;
    assign m_step_pin       = flags_reg.step_pin;
    assign m_dir_pin        = flags_reg.dir_pin;
    assign m_enable_n       = flags_reg.enable_n;
    assign m_busy_res       = flags_reg.busy;
    assign m_move_done      = flags_reg.done;
    assign m_start_rejected = flags_reg.rejected;
    assign m_current_period = period_reg;
    assign m_steps_left     = steps_reg;

endmodule

`default_nettype wire

// ===== sv/srpg_engine.sv =====
`default_nettype none

module srpg_engine import srpg_pkg::*; #(
    parameter int COUNT_WIDTH  = 32,
    parameter int PERIOD_WIDTH = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    fire,
    input  wire logic                    opcode,
    input  wire logic                    direction,
    input  wire logic [COUNT_WIDTH-1:0]  step_count,
    output res_flags_t                   flags,
    output logic      [PERIOD_WIDTH-1:0] period_out,
    output logic      [COUNT_WIDTH-1:0]  remaining_out
);

    logic [PERIOD_WIDTH-1:0] start_period_reg, min_period_reg, max_period_reg;
    logic [THRESH_W-1:0]     decel_threshold_reg;
    logic [STEP_W-1:0]       accel_decrement_reg, decel_increment_reg;
    logic                    hold_enable_reg;
    logic [STEP_W-1:0]       cfg_data16;

    logic [COUNT_WIDTH-1:0]  remaining_reg, remaining_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic [PERIOD_WIDTH-1:0] tick_left_reg, tick_left_next;
    logic                    pulse_high_reg, pulse_high_next;
    logic                    running_reg, running_next;
    logic                    dir_level_reg, dir_level_next;
    logic                    enable_n_reg, enable_n_next;
    logic                    done, rejected;

    logic [WIDE_W-1:0]       wide_period, wide_min, wide_acc, wide_sum;
    logic [PERIOD_WIDTH-1:0] period_adj;

    assign cfg_data16 = cfg_data[STEP_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_period_reg    <= PERIOD_WIDTH'(RST_START_PERIOD);
            min_period_reg      <= PERIOD_WIDTH'(RST_MIN_PERIOD);
            max_period_reg      <= PERIOD_WIDTH'(RST_MAX_PERIOD);
            decel_threshold_reg <= RST_DECEL_THRESHOLD;
            accel_decrement_reg <= RST_ACCEL_DECREMENT;
            decel_increment_reg <= RST_DECEL_INCREMENT;
            hold_enable_reg     <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_PERIOD:    start_period_reg    <= PERIOD_WIDTH'(cfg_data16);
                REG_MIN_PERIOD:      min_period_reg      <= PERIOD_WIDTH'(cfg_data16);
                REG_MAX_PERIOD:      max_period_reg      <= PERIOD_WIDTH'(cfg_data16);
                REG_DECEL_THRESHOLD: decel_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_ACCEL_DECREMENT: accel_decrement_reg <= cfg_data16;
                REG_DECEL_INCREMENT: decel_increment_reg <= cfg_data16;
                REG_HOLD_ENABLE:     hold_enable_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign wide_period = WIDE_W'(period_reg);
    assign wide_min    = WIDE_W'(min_period_reg);
    assign wide_acc    = WIDE_W'(accel_decrement_reg);
    assign wide_sum    = wide_period + WIDE_W'(decel_increment_reg);

    // ramp: accelerate above threshold, decelerate (saturating) otherwise
    always_comb begin
        period_adj = period_reg;
        if (THRESH_W'(remaining_reg) > decel_threshold_reg) begin
            if (period_reg > min_period_reg) begin
                if (wide_period >= wide_min + wide_acc) begin
                    period_adj = PERIOD_WIDTH'(wide_period - wide_acc);
                end else begin
                    period_adj = min_period_reg;
                end
            end
        end else if (period_reg < max_period_reg) begin
            if (wide_sum[WIDE_W-1:PERIOD_WIDTH] != '0) begin
                period_adj = '1;
            end else begin
                period_adj = PERIOD_WIDTH'(wide_sum);
            end
        end
    end

    always_comb begin
        remaining_next  = remaining_reg;
        period_next     = period_reg;
        tick_left_next  = tick_left_reg;
        pulse_high_next = pulse_high_reg;
        running_next    = running_reg;
        dir_level_next  = dir_level_reg;
        enable_n_next   = enable_n_reg;
        done            = 1'b0;
        rejected        = 1'b0;
        if (fire) begin
            if (opcode == OP_START) begin
                if (running_reg) begin
                    rejected = 1'b1;
                end else begin
                    dir_level_next = direction;
                    remaining_next = step_count;
                    period_next    = start_period_reg;
                    tick_left_next = start_period_reg;
                    if (step_count == '0) begin
                        done            = 1'b1;
                        pulse_high_next = 1'b0;
                        enable_n_next   = !hold_enable_reg;
                    end else begin
                        running_next    = 1'b1;
                        pulse_high_next = 1'b1;
                        enable_n_next   = 1'b0;
                    end
                end
            end else if (running_reg) begin
                if (tick_left_reg > PERIOD_WIDTH'(1)) begin
                    tick_left_next = tick_left_reg - PERIOD_WIDTH'(1);
                end else if (pulse_high_reg) begin
                    pulse_high_next = 1'b0;
                    tick_left_next  = period_reg;
                end else begin
                    period_next    = period_adj;
                    remaining_next = remaining_reg - COUNT_WIDTH'(1);
                    if (remaining_reg == COUNT_WIDTH'(1)) begin
                        running_next  = 1'b0;
                        done          = 1'b1;
                        enable_n_next = !hold_enable_reg;
                    end else begin
                        pulse_high_next = 1'b1;
                        tick_left_next  = period_adj;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg  <= '0;
            period_reg     <= '0;
            tick_left_reg  <= '0;
            pulse_high_reg <= 1'b0;
            running_reg    <= 1'b0;
            dir_level_reg  <= 1'b0;
            enable_n_reg   <= 1'b1;
        end else begin
            remaining_reg  <= remaining_next;
            period_reg     <= period_next;
            tick_left_reg  <= tick_left_next;
            pulse_high_reg <= pulse_high_next;
            running_reg    <= running_next;
            dir_level_reg  <= dir_level_next;
            enable_n_reg   <= enable_n_next;
        end
    end

    always_comb begin
        flags.step_pin = running_next && pulse_high_next;
        flags.dir_pin  = dir_level_next;
        flags.enable_n = enable_n_next;
        flags.busy     = running_next;
        flags.done     = done;
        flags.rejected = rejected;
    end

    assign period_out    = period_next;
    assign remaining_out = remaining_next;

    a_idle_pulse_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> !pulse_high_reg)
        else $error("step pulse high while idle");

    a_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> remaining_reg != '0)
        else $error("running with zero steps left");

    a_run_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> !enable_n_reg)
        else $error("driver disabled during move");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && done) |=> !running_reg)
        else $error("still running after move done");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && rejected) |=> running_reg && $stable(remaining_reg))
        else $error("rejected start disturbed the move");

endmodule

`default_nettype wire

// ===== tb/ramp_pulse_checker.sv =====
`timescale 1ns / 1ps

module ramp_pulse_checker import srpg_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic                   s_opcode,
    input  wire logic                   s_direction,
    input  wire logic [31:0]            s_step_count,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic                   m_step_pin,
    input  wire logic                   m_dir_pin,
    input  wire logic                   m_enable_n,
    input  wire logic                   m_busy_res,
    input  wire logic                   m_move_done,
    input  wire logic                   m_start_rejected,
    input  wire logic [15:0]            m_current_period,
    input  wire logic [31:0]            m_steps_left,
    output int                          mismatches,
    output int                          outstanding,
    output logic                        moving
);

    typedef struct packed {
        res_flags_t  flags;
        logic [15:0] period;
        logic [31:0] left;
    } pin_snap_t;

    pin_snap_t expected_snaps[$];

    logic [15:0] start_per, min_per, max_per, acc_step, dec_step;
    logic [31:0] thresh;
    logic        hold_en;

    logic [31:0] left_now;
    logic [15:0] per_now, ticks_now;
    logic        high_now, run_now, dir_now, en_n_now;

    function automatic void retune_period();
        logic [16:0] floor_sum;
        logic [16:0] ceil_sum;
        floor_sum = {1'b0, min_per} + {1'b0, acc_step};
        ceil_sum  = {1'b0, per_now} + {1'b0, dec_step};
        if (left_now > thresh) begin
            if (per_now > min_per)
                per_now = ({1'b0, per_now} >= floor_sum) ? per_now - acc_step : min_per;
        end else if (per_now < max_per) begin
            per_now = ceil_sum[16] ? 16'hFFFF : ceil_sum[15:0];
        end
    endfunction

    function automatic pin_snap_t advance_motor(input logic op, input logic dir,
                                                input logic [31:0] cnt);
        pin_snap_t snap;
        logic      done;
        logic      rejected;
        done     = 1'b0;
        rejected = 1'b0;
        if (op == OP_START) begin
            if (run_now) begin
                rejected = 1'b1;
            end else begin
                dir_now   = dir;
                en_n_now  = 1'b0;
                left_now  = cnt;
                per_now   = start_per;
                ticks_now = start_per;
                if (cnt == '0) begin
                    done     = 1'b1;
                    high_now = 1'b0;
                    en_n_now = !hold_en;
                end else begin
                    run_now  = 1'b1;
                    high_now = 1'b1;
                end
            end
        end else if (run_now) begin
            if (ticks_now > 16'd1) begin
                ticks_now = ticks_now - 16'd1;
            end else if (high_now) begin
                high_now  = 1'b0;
                ticks_now = per_now;
            end else begin
                retune_period();
                left_now = left_now - 32'd1;
                if (left_now == '0) begin
                    run_now  = 1'b0;
                    done     = 1'b1;
                    en_n_now = !hold_en;
                end else begin
                    high_now  = 1'b1;
                    ticks_now = per_now;
                end
            end
        end
        snap.flags.step_pin = run_now & high_now;
        snap.flags.dir_pin  = dir_now;
        snap.flags.enable_n = en_n_now;
        snap.flags.busy     = run_now;
        snap.flags.done     = done;
        snap.flags.rejected = rejected;
        snap.period         = per_now;
        snap.left           = left_now;
        return snap;
    endfunction

    always @(posedge aclk) begin
        pin_snap_t want;
        pin_snap_t got;
        if (!aresetn) begin
            start_per  = RST_START_PERIOD;
            min_per    = RST_MIN_PERIOD;
            max_per    = RST_MAX_PERIOD;
            thresh     = RST_DECEL_THRESHOLD;
            acc_step   = RST_ACCEL_DECREMENT;
            dec_step   = RST_DECEL_INCREMENT;
            hold_en    = 1'b0;
            left_now   = '0;
            per_now    = '0;
            ticks_now  = '0;
            high_now   = 1'b0;
            run_now    = 1'b0;
            dir_now    = 1'b0;
            en_n_now   = 1'b1;
            mismatches = 0;
            expected_snaps.delete();
            outstanding <= 0;
            moving      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_PERIOD:    start_per = cfg_data[15:0];
                    REG_MIN_PERIOD:      min_per   = cfg_data[15:0];
                    REG_MAX_PERIOD:      max_per   = cfg_data[15:0];
                    REG_DECEL_THRESHOLD: thresh    = cfg_data[31:0];
                    REG_ACCEL_DECREMENT: acc_step  = cfg_data[15:0];
                    REG_DECEL_INCREMENT: dec_step  = cfg_data[15:0];
                    REG_HOLD_ENABLE:     hold_en   = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_step_pin, m_dir_pin, m_enable_n, m_busy_res, m_move_done,
                       m_start_rejected, m_current_period, m_steps_left};
                if (expected_snaps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("chk: result beat with nothing expected at %0t", $time);
                end else begin
                    want = expected_snaps.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("chk: result mismatch at %0t", $time);
                            $display("  want step=%0b dir=%0b en_n=%0b busy=%0b done=%0b",
                                     want.flags.step_pin, want.flags.dir_pin,
                                     want.flags.enable_n, want.flags.busy, want.flags.done);
                            $display("       rej=%0b period=%0d left=%0d",
                                     want.flags.rejected, want.period, want.left);
                            $display("  got  step=%0b dir=%0b en_n=%0b busy=%0b done=%0b",
                                     got.flags.step_pin, got.flags.dir_pin,
                                     got.flags.enable_n, got.flags.busy, got.flags.done);
                            $display("       rej=%0b period=%0d left=%0d",
                                     got.flags.rejected, got.period, got.left);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                expected_snaps.push_back(advance_motor(s_opcode, s_direction, s_step_count));
            outstanding <= expected_snaps.size();
            moving      <= run_now;
        end
    end

endmodule

// ===== tb/stepper_ramp_pulse_generator_tb.sv =====
`timescale 1ns / 1ps

module stepper_ramp_pulse_generator_tb import srpg_pkg::*; ();

    localparam int RUN_LIMIT   = 400000;
    localparam int BEAT_TARGET = 520;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_opcode;
    logic                   s_direction;
    logic [31:0]            s_step_count;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_step_pin;
    logic                   m_dir_pin;
    logic                   m_enable_n;
    logic                   m_busy_res;
    logic                   m_move_done;
    logic                   m_start_rejected;
    logic [15:0]            m_current_period;
    logic [31:0]            m_steps_left;

    int   mismatches;
    int   outstanding;
    logic moving;
    int   hold_cycles = 0;
    int   beats_sent = 0;
    int   cycles = 0;
    logic tx_burst = 1'b0;

    stepper_ramp_pulse_generator u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_direction      (s_direction),
        .s_step_count     (s_step_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_pin       (m_step_pin),
        .m_dir_pin        (m_dir_pin),
        .m_enable_n       (m_enable_n),
        .m_busy_res       (m_busy_res),
        .m_move_done      (m_move_done),
        .m_start_rejected (m_start_rejected),
        .m_current_period (m_current_period),
        .m_steps_left     (m_steps_left)
    );

    ramp_pulse_checker u_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_direction      (s_direction),
        .s_step_count     (s_step_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_pin       (m_step_pin),
        .m_dir_pin        (m_dir_pin),
        .m_enable_n       (m_enable_n),
        .m_busy_res       (m_busy_res),
        .m_move_done      (m_move_done),
        .m_start_rejected (m_start_rejected),
        .m_current_period (m_current_period),
        .m_steps_left     (m_steps_left),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .moving           (moving)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random back-pressure, with one long hold-off on request
    initial begin
        int   r;
        int   n;
        logic held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (hold_cycles > 0 && !held) begin
                n = hold_cycles;
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_ready <= 1'b1;
                    n = $urandom_range(1, 24);
                end else if (r < 93) begin
                    m_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    n = $urandom_range(10, 40);
                end
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic op, input logic dir, input logic [31:0] cnt);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (!tx_burst && r >= 65) begin
            n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_direction  <= dir;
        s_step_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // tick until the move is over, now and then throwing in a start
    task automatic tick_out(input int noise_pct);
        int k;
        k = 0;
        do begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(OP_START, 1'($urandom_range(0, 1)), $urandom_range(0, 6));
            else
                send_beat(OP_TICK, 1'($urandom_range(0, 1)), $urandom());
            k++;
        end while (moving && k < 1000);
    endtask

    task automatic run_move(input logic dir, input logic [31:0] cnt, input int noise_pct);
        send_beat(OP_START, dir, cnt);
        tick_out(noise_pct);
    endtask

    // drop valid and wait until every beat has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] sp, input logic [15:0] mn,
                                input logic [15:0] mx, input logic [31:0] th,
                                input logic [15:0] ac, input logic [15:0] dc,
                                input logic hd);
        put_reg(REG_START_PERIOD, {16'd0, sp});
        put_reg(REG_MIN_PERIOD, {16'd0, mn});
        put_reg(REG_MAX_PERIOD, {16'd0, mx});
        put_reg(REG_DECEL_THRESHOLD, th);
        put_reg(REG_ACCEL_DECREMENT, {16'd0, ac});
        put_reg(REG_DECEL_INCREMENT, {16'd0, dc});
        put_reg(REG_HOLD_ENABLE, {31'd0, hd});
        cfg_we <= 1'b0;
    endtask

    initial begin
        int          r;
        int          moves;
        int          phase;
        logic [31:0] cnt;
        logic [15:0] sp, mn, mx, ac, dc;
        logic [31:0] th;
        logic        hd;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_opcode     = OP_TICK;
        s_direction  = 1'b0;
        s_step_count = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle tick, then a zero-length move on reset settings
        send_beat(OP_TICK, 1'b1, 32'hFFFF_FFFF);
        send_beat(OP_START, 1'b1, 32'd0);
        settle();

        // zero start period, decelerating straight to the top
        program_regs(16'd0, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b1);
        run_move(1'b0, 32'd1, 0);
        settle();

        // decel add saturates; a start while busy is dropped
        program_regs(16'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b0);
        send_beat(OP_START, 1'b1, 32'd1);
        send_beat(OP_START, 1'b0, 32'hFFFF_FFFF);
        tick_out(0);
        settle();

        // accel step overshoots the floor
        program_regs(16'd3, 16'd1, 16'd1, 32'd0, 16'hFFFF, 16'd0, 1'b0);
        run_move(1'b1, 32'd2, 0);

        phase = 0;
        while (beats_sent < BEAT_TARGET) begin
            settle();
            sp = 16'($urandom_range(1, 6));
            r  = $urandom_range(0, 99);
            mn = (r < 80) ? 16'($urandom_range(1, 4)) : 16'hFFFF;
            r  = $urandom_range(0, 99);
            mx = (r < 15) ? 16'd1 : (r < 30) ? 16'hFFFF : 16'($urandom_range(2, 12));
            r  = $urandom_range(0, 99);
            th = (r < 20) ? 32'd0 : (r < 35) ? 32'hFFFF_FFFF :
                 (r < 45) ? $urandom() : $urandom_range(0, 5);
            r  = $urandom_range(0, 99);
            ac = (r < 15) ? 16'hFFFF : 16'($urandom_range(0, 3));
            dc = 16'($urandom_range(0, 3));
            hd = 1'($urandom_range(0, 1));
            program_regs(sp, mn, mx, th, ac, dc, hd);
            tx_burst = ($urandom_range(0, 3) == 0);
            moves = $urandom_range(3, 8);
            for (int m = 0; m < moves; m++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_beat(OP_TICK, 1'($urandom_range(0, 1)), $urandom());
                cnt = (r < 20) ? 32'd0 : $urandom_range(1, 6);
                if (phase == 0 && m == 0) begin
                    // hold the result side off so the block backs up
                    hold_cycles = 300;
                    tx_burst    = 1'b1;
                    cnt         = 32'd6;
                end
                run_move(1'($urandom_range(0, 1)), cnt, 5);
            end
            phase++;
        end
        tx_burst = 1'b0;
        settle();

        // longest period and full-width count; the move never ends
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(OP_START, 1'b1, 32'hFFFF_FFFF);
        repeat (5) send_beat(OP_TICK, 1'($urandom_range(0, 1)), $urandom());
        send_beat(OP_START, 1'b0, 32'd0);
        settle();
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
